### rtl/slbc_pkg.sv
// ----------------------------------------------------------------------------
// slbc_pkg: shared types and constants of the scan-line band centroid block
// Holds the geometry constants, register codes, the per-frame accumulator
// snapshot type and the scan-line center function.
// ----------------------------------------------------------------------------
`default_nettype none
package slbc_pkg;

   localparam int NUM_LINES   = 8;
   localparam int COORD_BITS  = 12;
   localparam int LINE_W      = $clog2(NUM_LINES);
   localparam int LINE_IDX_W  = 4;
   localparam int THR_W       = 8;
   localparam int BAND_W      = 6;
   localparam int HALF_W      = BAND_W - 1;
   localparam int SUM_W       = 19;
   localparam int CNT_W       = 7;
   localparam int LR_W        = COORD_BITS + 1;
   localparam int CENTER_W    = COORD_BITS + 2;
   localparam int OFFSET_W    = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = COORD_BITS;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // center offset k*span/(NUM_LINES-1) by reciprocal multiplication
   localparam int K_W        = 4;
   localparam int KS_W       = COORD_BITS + K_W;
   localparam int DIV_D      = NUM_LINES - 1;
   localparam int DIV_SHIFT  = 26;
   localparam int RECIP_W    = DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + DIV_D - 1) / DIV_D);

   // divider of the back part
   localparam int PROD_W  = CNT_W + COORD_BITS;
   localparam int DIFF_W  = SUM_W + 2;
   localparam int MAG_W   = DIFF_W + 3;
   localparam int STEP_W  = $clog2(MAG_W);

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLACK_THRESHOLD = 3'd0,
      REG_IMAGE_WIDTH     = 3'd1,
      REG_IMAGE_HEIGHT    = 3'd2,
      REG_SCAN_BOTTOM_ROW = 3'd3,
      REG_SCAN_SPAN       = 3'd4,
      REG_BAND_HEIGHT     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]      black_threshold;
      logic [COORD_BITS-1:0] image_width;
      logic [COORD_BITS-1:0] image_height;
      logic [COORD_BITS-1:0] scan_bottom_row;
      logic [COORD_BITS-1:0] scan_span;
      logic [BAND_W-1:0]     band_height;
   } cfg_type;

   typedef logic [NUM_LINES-1:0][CENTER_W-1:0] centers_type;

   typedef struct packed {
      logic [NUM_LINES-1:0][SUM_W-1:0] sum;
      logic [NUM_LINES-1:0][CNT_W-1:0] cnt;
   } frame_acc_type;

   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [FIFO_CNT_W-1:0] count;
   } queue_ctl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIFF,
      BK_DIV,
      BK_FIN,
      BK_OUT
   } back_state_type;

   function automatic logic [COORD_BITS-1:0] last_index(input logic [COORD_BITS-1:0] n);
      return (n == '0) ? '0 : n - 1'b1;
   endfunction

   // center row of scan line i: bottom - floor((N-1-i)*span/(N-1))
   function automatic logic [CENTER_W-1:0] line_center(
      input logic [COORD_BITS-1:0] bottom,
      input logic [COORD_BITS-1:0] span,
      input logic [K_W-1:0]        k
   );
      logic [KS_W-1:0]         ks;
      logic [KS_W+RECIP_W-1:0] prod;
      logic [COORD_BITS-1:0]   off;
      ks   = KS_W'(k) * KS_W'(span);
      prod = (KS_W+RECIP_W)'(ks) * (KS_W+RECIP_W)'(DIV_RECIP);
      off  = COORD_BITS'(prod >> DIV_SHIFT);
      return CENTER_W'(bottom) - CENTER_W'(off);
   endfunction

endpackage
`default_nettype wire

### rtl/slbc_if.sv
// ----------------------------------------------------------------------------
// slbc_if: pixel and result channel interfaces
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface slbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] brightness;
   modport source (output valid, output brightness, input ready);
   modport sink   (input valid, input brightness, output ready);
endinterface

interface slbc_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         line_index;
   logic [11:0]        scan_row_number;
   logic               line_found;
   logic signed [15:0] lateral_offset_q4;
   logic               any_line_found;
   logic               last_of_frame;
   modport source (output valid, output line_index, output scan_row_number,
                   output line_found, output lateral_offset_q4,
                   output any_line_found, output last_of_frame, input ready);
   modport sink   (input valid, input line_index, input scan_row_number,
                   input line_found, input lateral_offset_q4,
                   input any_line_found, input last_of_frame, output ready);
endinterface
`default_nettype wire

### rtl/slbc_front.sv
// ----------------------------------------------------------------------------
// slbc_front: pixel front end
// Counts column and row, finds the dark span of each row, adds its left plus
// right edge into the band accumulators and pushes a snapshot at each frame end.
// ----------------------------------------------------------------------------
`default_nettype none
module slbc_front import slbc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire centers_type   centers,
   slbc_req_if.sink           req,
   input  wire logic [FIFO_CNT_W-1:0] queue_count,
   output logic               push,
   output frame_acc_type      push_data
);

   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [COORD_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic                  has_ff, has_in;

   logic                  ev_valid_ff, ev_valid_in;
   logic                  ev_frame_ff, ev_frame_in;
   logic                  ev_close_ff, ev_close_in;
   logic [COORD_BITS-1:0] ev_row_ff, ev_row_in;
   logic [LR_W-1:0]       ev_lr_ff, ev_lr_in;

   logic [NUM_LINES-1:0][SUM_W-1:0] sum_ff, sum_in, sum_upd;
   logic [NUM_LINES-1:0][CNT_W-1:0] cnt_ff, cnt_in, cnt_upd;

   logic                  accept, dark, row_end, frame_end, has_now;
   logic [COORD_BITS-1:0] left_now, right_now;
   logic [FIFO_CNT_W:0]   pending;

   // hold off pixels unless the queue has room for any frame end in flight
   always_comb begin
      pending   = (FIFO_CNT_W+1)'(queue_count) + (FIFO_CNT_W+1)'(ev_valid_ff && ev_frame_ff);
      req.ready = pending < (FIFO_CNT_W+1)'(FIFO_DEPTH);
   end

   // classify the pixel and advance the raster position
   always_comb begin
      accept    = req.valid && req.ready;
      dark      = req.brightness < cfg.black_threshold;
      left_now  = (dark && !has_ff) ? col_ff : left_ff;
      right_now = dark ? col_ff : right_ff;
      has_now   = has_ff || dark;
      row_end   = col_ff >= last_index(cfg.image_width);
      frame_end = row_ff >= last_index(cfg.image_height);

      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      has_in   = has_ff;
      if (accept) begin
         if (row_end) begin
            col_in   = '0;
            left_in  = '0;
            right_in = '0;
            has_in   = 1'b0;
            row_in   = frame_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in   = col_ff + 1'b1;
            left_in  = left_now;
            right_in = right_now;
            has_in   = has_now;
         end
      end

      ev_valid_in = accept && row_end;
      ev_frame_in = frame_end;
      ev_close_in = has_now && (row_ff <= last_index(cfg.image_height));
      ev_row_in   = row_ff;
      ev_lr_in    = LR_W'(left_now) + LR_W'(right_now);
   end

   // add the closed row into every band that covers it
   always_comb begin
      logic signed [CENTER_W:0] c, lo, hi, r;
      logic [SUM_W:0]           s;
      r = $signed({2'b00, ev_row_ff});
      for (int i = 0; i < NUM_LINES; i++) begin
         c  = $signed({centers[i][CENTER_W-1], centers[i]});
         lo = c - $signed((CENTER_W+1)'(cfg.band_height >> 1));
         hi = c + $signed((CENTER_W+1)'(cfg.band_height >> 1));
         s  = (SUM_W+1)'(sum_ff[i]) + (SUM_W+1)'(ev_lr_ff);
         sum_upd[i] = sum_ff[i];
         cnt_upd[i] = cnt_ff[i];
         if (ev_close_ff && r >= lo && r <= hi) begin
            sum_upd[i] = s > (SUM_W+1)'(SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
            cnt_upd[i] = (cnt_ff[i] == CNT_MAX) ? CNT_MAX : cnt_ff[i] + 1'b1;
         end
      end
      push          = ev_valid_ff && ev_frame_ff;
      push_data.sum = sum_upd;
      push_data.cnt = cnt_upd;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (ev_valid_ff) begin
         sum_in = push ? '0 : sum_upd;
         cnt_in = push ? '0 : cnt_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         right_ff    <= '0;
         has_ff      <= 1'b0;
         ev_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         has_ff      <= has_in;
         ev_valid_ff <= ev_valid_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
      end
   end

   // row event payload
   always_ff @(posedge clock) begin
      ev_frame_ff <= ev_frame_in;
      ev_close_ff <= ev_close_in;
      ev_row_ff   <= ev_row_in;
      ev_lr_ff    <= ev_lr_in;
   end

endmodule
`default_nettype wire

### rtl/slbc_queue.sv
// ----------------------------------------------------------------------------
// slbc_queue: frame snapshot queue
// Short FIFO of band accumulator snapshots between front and back part.
// ----------------------------------------------------------------------------
`default_nettype none
module slbc_queue import slbc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire frame_acc_type push_data,
   input  wire logic          pop,
   output frame_acc_type      head,
   output logic               empty,
   output logic [FIFO_CNT_W-1:0] count
);

   frame_acc_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, rd_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   queue_ctl_type         ctl;

   always_comb begin
      ctl.push  = push;
      ctl.pop   = pop && (count_ff != '0);
      ctl.count = count_ff;
      empty     = (count_ff == '0);
      count     = count_ff;
      head      = mem_ff[rd_ff];
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (ctl.push) wr_ff <= wr_ff + 1'b1;
         if (ctl.pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= ctl.count + FIFO_CNT_W'(ctl.push) - FIFO_CNT_W'(ctl.pop);
      end
   end

   // store snapshot
   always_ff @(posedge clock) begin
      if (ctl.push) mem_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

### rtl/slbc_back.sv
// ----------------------------------------------------------------------------
// slbc_back: per-line result engine
// Takes one frame snapshot, divides each band sum minus cnt*width by its row
// count with a bit-serial divider and delivers one result per scan line.
// ----------------------------------------------------------------------------
`default_nettype none
module slbc_back import slbc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire centers_type   centers,
   input  wire frame_acc_type head,
   input  wire logic          empty,
   output logic               pop,
   slbc_rsp_if.source         rsp
);

   back_state_type state_ff, state_in;

   logic [LINE_W-1:0]     line_ff, line_in;
   logic                  any_ff, any_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic                  out_valid_ff, out_valid_in;
   logic [LINE_IDX_W-1:0] o_line_ff, o_line_in;
   logic [COORD_BITS-1:0] o_row_ff, o_row_in;
   logic                  o_found_ff, o_found_in;
   logic [OFFSET_W-1:0]   o_off_ff, o_off_in;
   logic                  o_any_ff, o_any_in;
   logic                  o_last_ff, o_last_in;

   assign rsp.valid             = out_valid_ff;
   assign rsp.line_index        = o_line_ff;
   assign rsp.scan_row_number   = o_row_ff;
   assign rsp.line_found        = o_found_ff;
   assign rsp.lateral_offset_q4 = o_off_ff;
   assign rsp.any_line_found    = o_any_ff;
   assign rsp.last_of_frame     = o_last_ff;

   // sequence the lines of one snapshot
   always_comb begin
      logic signed [DIFF_W-1:0]   diff;
      logic signed [MAG_W-1:0]    num;
      logic [CNT_W:0]             rem_sh;
      logic [MAG_W:0]             qadj;
      logic signed [CENTER_W-1:0] c;
      logic [COORD_BITS-1:0]      last_row;

      state_in     = state_ff;
      line_in      = line_ff;
      any_in       = any_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      o_line_in    = o_line_ff;
      o_row_in     = o_row_ff;
      o_found_in   = o_found_ff;
      o_off_in     = o_off_ff;
      o_any_in     = o_any_ff;
      o_last_in    = o_last_ff;
      pop          = 1'b0;

      diff     = $signed(DIFF_W'(sum_ff)) - $signed(DIFF_W'(prod_ff));
      num      = $signed(MAG_W'(diff)) <<< 3;
      rem_sh   = {rem_ff[CNT_W-1:0], quo_ff[MAG_W-1]};
      qadj     = (MAG_W+1)'(quo_ff) + (MAG_W+1)'(rem_ff != '0);
      c        = $signed(centers[line_ff]);
      last_row = last_index(cfg.image_height);

      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               line_in  = '0;
               any_in   = |head.cnt;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            cnt_in   = head.cnt[line_ff];
            sum_in   = head.sum[line_ff];
            prod_in  = PROD_W'(head.cnt[line_ff]) * PROD_W'(cfg.image_width);
            state_in = BK_DIFF;
         end
         BK_DIFF: begin
            neg_in   = num < 0;
            quo_in   = (num < 0) ? MAG_W'(-num) : MAG_W'(num);
            rem_in   = '0;
            step_in  = '0;
            state_in = (cnt_ff == '0) ? BK_FIN : BK_DIV;
         end
         BK_DIV: begin
            // one quotient bit per cycle
            if (rem_sh >= (CNT_W+1)'(cnt_ff)) begin
               rem_in = rem_sh - (CNT_W+1)'(cnt_ff);
               quo_in = {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[MAG_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAG_W - 1)) state_in = BK_FIN;
         end
         BK_FIN: begin
            o_line_in  = LINE_IDX_W'(line_ff);
            o_found_in = (cnt_ff != '0);
            o_any_in   = any_ff;
            o_last_in  = (line_ff == LINE_W'(NUM_LINES - 1));
            if (c < 0)
               o_row_in = '0;
            else if (c > $signed(CENTER_W'(last_row)))
               o_row_in = last_row;
            else
               o_row_in = c[COORD_BITS-1:0];
            if (cnt_ff == '0)
               o_off_in = '0;
            else if (neg_ff)
               o_off_in = (qadj > (MAG_W+1)'(32768)) ? 16'h8000 : OFFSET_W'(-qadj);
            else
               o_off_in = (quo_ff > MAG_W'(32767)) ? 16'h7fff : quo_ff[OFFSET_W-1:0];
            out_valid_in = 1'b1;
            state_in     = BK_OUT;
         end
         BK_OUT: begin
            if (rsp.ready) begin
               out_valid_in = 1'b0;
               if (line_ff == LINE_W'(NUM_LINES - 1)) begin
                  pop      = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  line_in  = line_ff + 1'b1;
                  state_in = BK_MUL;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         line_ff      <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         line_ff      <= line_in;
         step_ff      <= step_in;
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      any_ff     <= any_in;
      cnt_ff     <= cnt_in;
      sum_ff     <= sum_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      o_line_ff  <= o_line_in;
      o_row_ff   <= o_row_in;
      o_found_ff <= o_found_in;
      o_off_ff   <= o_off_in;
      o_any_ff   <= o_any_in;
      o_last_ff  <= o_last_in;
   end

endmodule
`default_nettype wire

### rtl/scanline_band_line_centroid_top.sv
// ----------------------------------------------------------------------------
// scanline_band_line_centroid_top: scan-line band centroid tracker
// Pixels enter on req in raster order, one byte each; the block counts
// column and row itself and needs no frame or line markers.
// A pixel is taken every cycle while req.ready is high. At the last pixel of
// a frame the band sums are copied into a two-entry snapshot queue.
// The back part turns each snapshot into NUM_LINES results on rsp, top line
// first, last_of_frame on the final one. Each found line passes through load
// and multiply, difference, a 24-step divider and format; a line with no dark
// row skips the divider. If rsp stalls, the back part holds its result and the
// queue fills; req.ready drops for every pixel while the queue holds two
// snapshots, or one with a second being written, and rises again once the back
// part frees an entry. Registers are written on csr_write_enable at csr_index;
// the user must write them only while idle, which the block does not enforce.
// The centers follow in the next cycle. Reset restores register defaults and
// clears counters, accumulators and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module scanline_band_line_centroid_top import slbc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   slbc_req_if.sink                   req,
   slbc_rsp_if.source                 rsp,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type               cfg_ff;
   centers_type           centers_ff, centers_in;
   logic                  push, pop, empty;
   frame_acc_type         push_data, head;
   logic [FIFO_CNT_W-1:0] queue_count;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black_threshold <= THR_W'(60);
         cfg_ff.image_width     <= COORD_BITS'(640);
         cfg_ff.image_height    <= COORD_BITS'(480);
         cfg_ff.scan_bottom_row <= COORD_BITS'(432);
         cfg_ff.scan_span       <= COORD_BITS'(192);
         cfg_ff.band_height     <= BAND_W'(4);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BLACK_THRESHOLD: cfg_ff.black_threshold <= csr_data[THR_W-1:0];
            REG_IMAGE_WIDTH:     cfg_ff.image_width     <= csr_data;
            REG_IMAGE_HEIGHT:    cfg_ff.image_height    <= csr_data;
            REG_SCAN_BOTTOM_ROW: cfg_ff.scan_bottom_row <= csr_data;
            REG_SCAN_SPAN:       cfg_ff.scan_span       <= csr_data;
            REG_BAND_HEIGHT:     cfg_ff.band_height     <= csr_data[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // scan-line centers, one lane per line
   always_comb begin
      for (int i = 0; i < NUM_LINES; i++)
         centers_in[i] = line_center(cfg_ff.scan_bottom_row, cfg_ff.scan_span,
                                     K_W'(NUM_LINES - 1 - i));
   end

   always_ff @(posedge clock) begin
      centers_ff <= centers_in;
   end

   slbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .centers     (centers_ff),
      .req         (req),
      .queue_count (queue_count),
      .push        (push),
      .push_data   (push_data)
   );

   slbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .count     (queue_count)
   );

   slbc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .centers (centers_ff),
      .head    (head),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule
`default_nettype wire

### rtl/slbc_checker.sv
// ----------------------------------------------------------------------------
// slbc_checker: port-level checks of the centroid tracker
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module slbc_checker import slbc_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [LINE_IDX_W-1:0] rsp_line_index,
   input wire logic                  rsp_line_found,
   input wire logic [OFFSET_W-1:0]   rsp_lateral_offset_q4,
   input wire logic                  rsp_any_line_found,
   input wire logic                  rsp_last_of_frame
);

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_index)
         && $stable(rsp_lateral_offset_q4))
      else $error("result changed while stalled");

   // last flag marks the bottom line only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_of_frame == (rsp_line_index == LINE_IDX_W'(NUM_LINES - 1)))
      else $error("last_of_frame on wrong line");

   // a missing line carries a zero offset
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_found |-> rsp_lateral_offset_q4 == '0)
      else $error("offset without a found line");

   // a found line implies the frame flag
   a_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_found |-> rsp_any_line_found)
      else $error("line found but frame flag clear");

endmodule

bind scanline_band_line_centroid_top slbc_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_line_index        (rsp.line_index),
   .rsp_line_found        (rsp.line_found),
   .rsp_lateral_offset_q4 (rsp.lateral_offset_q4),
   .rsp_any_line_found    (rsp.any_line_found),
   .rsp_last_of_frame     (rsp.last_of_frame)
);
`default_nettype wire
